// ===== hdl/command_line_argument_tokenizer_top_assert.svh =====
// assertion macros for the argument tokenizer top level
// depends on nothing; included by command_line_argument_tokenizer_top
`ifndef COMMAND_LINE_ARGUMENT_TOKENIZER_TOP_ASSERT_SVH
`define COMMAND_LINE_ARGUMENT_TOKENIZER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CLAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");
`define CLAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");
`else
`define CLAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CLAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/clat_pkg.sv =====
// shared types and constants of the argument tokenizer
// no dependencies
package clat_pkg;

  localparam int PEND_W = 6;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_MARK = 1'b1;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_WORD    = 2'd1,
    MODE_QUOTE   = 2'd2,
    MODE_COMMENT = 2'd3
  } mode_t;

  typedef struct packed {
    logic load;
    logic dec;
    logic sel_tail;
  } clat_cmd_t;

  typedef struct packed {
    logic job_bs_nz;
    logic job_tail;
    logic cnt_one;
    logic tail_pend;
  } clat_sts_t;

endpackage

// ===== hdl/clat_ctrl.sv =====
// tokenizer controller: input acceptance and result sequencing
// depends on clat_pkg
module clat_ctrl import clat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  clat_sts_t sts,
  output clat_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FLUSH = 3'b010,
    S_TAIL  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = (state_r == S_FLUSH) || (state_r == S_TAIL);
  assign cmd.load     = in_valid && in_ready;
  assign cmd.dec      = (state_r == S_FLUSH) && out_ready;
  assign cmd.sel_tail = (state_r == S_TAIL);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          if (sts.job_bs_nz) state_nxt = S_FLUSH;
          else if (sts.job_tail) state_nxt = S_TAIL;
        end
      end
      S_FLUSH: begin
        if (out_ready && sts.cnt_one) state_nxt = sts.tail_pend ? S_TAIL : S_IDLE;
      end
      S_TAIL: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ===== hdl/clat_dp.sv =====
// tokenizer datapath: scan state, byte decode and pending result registers
// depends on clat_pkg
module clat_dp import clat_pkg::*; #(
  parameter int MAX_PENDING = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  input  clat_cmd_t  cmd,
  output clat_sts_t  sts,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_overflow
);

  localparam logic [PEND_W-1:0] MAXP = PEND_W'(MAX_PENDING);

  mode_t             mode_r, mode_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              ne_r, ne_nxt;
  logic              ovf_r, ovf_nxt;

  logic [PEND_W-1:0] cnt_r, job_cnt;
  logic              tail_r, job_tail;
  logic              kind_r, job_kind;
  logic [7:0]        byte_r, job_byte;
  logic              jovf_r;

  logic is_ws, is_q, is_hash, is_bs, is_lf, is_cr;

  assign is_ws   = (in_text_byte == CH_SPACE) ||
                   ((in_text_byte >= CH_TAB) && (in_text_byte <= CH_CR));
  assign is_q    = (in_text_byte == CH_QUOTE);
  assign is_hash = (in_text_byte == CH_HASH);
  assign is_bs   = (in_text_byte == CH_BSLASH);
  assign is_lf   = (in_text_byte == CH_LF);
  assign is_cr   = (in_text_byte == CH_CR);

  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    ne_nxt   = ne_r;
    ovf_nxt  = ovf_r;
    job_cnt  = '0;
    job_tail = 1'b0;
    job_kind = KIND_CHAR;
    job_byte = in_text_byte;
    if (in_end_of_text || ((mode_r == MODE_BETWEEN || mode_r == MODE_WORD) && is_ws) ||
        (mode_r == MODE_QUOTE && is_lf)) begin
      // end of argument
      if (ne_r || (pend_r != '0)) begin
        job_cnt  = pend_r;
        job_tail = 1'b1;
        job_kind = KIND_MARK;
        job_byte = '0;
      end
      pend_nxt = '0;
      ne_nxt   = 1'b0;
      ovf_nxt  = 1'b0;
      mode_nxt = MODE_BETWEEN;
    end else begin
      unique case (mode_r)
        MODE_BETWEEN, MODE_WORD: begin
          if (is_q) begin
            if (pend_r[0]) begin
              job_cnt  = pend_r >> 1;
              job_tail = 1'b1;
              pend_nxt = '0;
              ne_nxt   = 1'b1;
              mode_nxt = MODE_BETWEEN;
            end else begin
              pend_nxt = pend_r >> 1;
              mode_nxt = MODE_QUOTE;
            end
          end else if (is_hash && mode_r == MODE_BETWEEN) begin
            mode_nxt = MODE_COMMENT;
          end else if (is_bs) begin
            if (pend_r >= MAXP) ovf_nxt = 1'b1;
            else pend_nxt = pend_r + PEND_W'(1);
            mode_nxt = MODE_WORD;
          end else begin
            job_cnt  = pend_r;
            job_tail = 1'b1;
            pend_nxt = '0;
            ne_nxt   = 1'b1;
            mode_nxt = MODE_WORD;
          end
        end
        MODE_QUOTE: begin
          if (is_q) begin
            if (pend_r[0]) begin
              job_cnt  = pend_r >> 1;
              job_tail = 1'b1;
              pend_nxt = '0;
              ne_nxt   = 1'b1;
            end else begin
              pend_nxt = pend_r >> 1;
              mode_nxt = MODE_BETWEEN;
            end
          end else if (is_cr) begin
            // dropped inside quotes
          end else if (is_bs) begin
            if (pend_r >= MAXP) ovf_nxt = 1'b1;
            else pend_nxt = pend_r + PEND_W'(1);
          end else begin
            job_cnt  = pend_r;
            job_tail = 1'b1;
            pend_nxt = '0;
            ne_nxt   = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (is_lf || is_cr) mode_nxt = MODE_BETWEEN;
        end
        default: mode_nxt = MODE_BETWEEN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BETWEEN;
      pend_r <= '0;
      ne_r   <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
      tail_r <= 1'b0;
    end else if (cmd.load) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      ne_r   <= ne_nxt;
      ovf_r  <= ovf_nxt;
      cnt_r  <= job_cnt;
      tail_r <= job_tail;
    end else if (cmd.dec) begin
      cnt_r <= cnt_r - PEND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= job_kind;
      byte_r <= job_byte;
      jovf_r <= ovf_r;
    end
  end

  assign sts.job_bs_nz = (job_cnt != '0);
  assign sts.job_tail  = job_tail;
  assign sts.cnt_one   = (cnt_r == PEND_W'(1));
  assign sts.tail_pend = tail_r;

  assign out_kind     = cmd.sel_tail ? kind_r : KIND_CHAR;
  assign out_byte     = cmd.sel_tail ? byte_r : CH_BSLASH;
  assign out_last     = cmd.sel_tail || (sts.cnt_one && !tail_r);
  assign out_overflow = jovf_r;

endmodule

// ===== hdl/command_line_argument_tokenizer_top.sv =====
// argument tokenizer: one text byte in, zero or more argument results out
// a byte with no results only updates the scan state; a byte with k results, k up to MAX_PENDING+1,
// gives them at one per cycle while out_ready is high, from the cycle after the transfer
// the result sequencer handles one byte at a time; the next byte is taken after the last
// result transfer; synchronous active-low reset returns to between-tokens, nothing held
module command_line_argument_tokenizer_top import clat_pkg::*; #(
  parameter int MAX_PENDING = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_overflow
);

`include "command_line_argument_tokenizer_top_assert.svh"

  clat_cmd_t cmd;
  clat_sts_t sts;

  clat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  clat_dp #(
    .MAX_PENDING (MAX_PENDING)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .cmd            (cmd),
    .sts            (sts),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_overflow   (out_overflow)
  );

  `CLAT_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `CLAT_ASSERT_NEXT(a_last_idle, clk, rst_n, out_valid && out_ready && out_last, in_ready)
  `CLAT_ASSERT_NOW(a_mark_last, clk, rst_n, out_valid && out_kind, out_last && (out_byte == 8'h00))
  `CLAT_ASSERT_NEXT(a_more_follow, clk, rst_n, out_valid && out_ready && !out_last, out_valid)

endmodule
